// ----- sv/speech_endpoint_detector_core_defines.svh -----
// Assertion macros shared by the endpoint detector RTL.
// Relies on aclk and aresetn being visible in the including module.
`ifndef SPEECH_ENDPOINT_DETECTOR_CORE_DEFINES_SVH
`define SPEECH_ENDPOINT_DETECTOR_CORE_DEFINES_SVH

// Clocked check, off while reset is held.
`define SED_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SED_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- sv/sed_pkg.sv -----
// Shared types and constants of the speech endpoint detector.
// No dependencies.
package sed_pkg;

    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CMD_W           = 2;
    localparam int EV_W            = 2;
    localparam int PHASE_W         = 2;
    localparam int S_TDATA_W       = 8;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FRAMES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAMES     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAMES     = 2'd3;

    localparam logic [CFG_W-1:0] START_FRAMES_RST   = 16'd3;
    localparam logic [CFG_W-1:0] SILENCE_FRAMES_RST = 16'd80;
    localparam logic [CFG_W-1:0] MIN_FRAMES_RST     = 16'd25;
    localparam logic [CFG_W-1:0] MAX_FRAMES_RST     = 16'd3000;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FORCE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_START = 2'd1;
    localparam logic [EV_W-1:0] EV_END   = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             voiced;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               force_accepted;
        logic               limit_hit;
        logic               discarded;
        logic [EV_W-1:0]    event_res;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] start_frames;
        logic [CFG_W-1:0] silence_frames;
        logic [CFG_W-1:0] min_frames;
        logic [CFG_W-1:0] max_frames;
    } cfg_t;

endpackage

// ----- sv/speech_endpoint_detector_core.sv -----
// Speech endpoint detector core: per-frame voice decisions in, utterance events out.
// Depends on sed_pkg, sed_in_stage, sed_ctrl and sed_out_stage.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the command (frame decision,
//   clear to waiting, force end, or no-op), s_tdata bit 0 carries the voice decision.
//   Every request yields exactly one result on the m_ stream holding the event
//   (start/end), discard, limit and force flags and the phase after the request.
//   Set thresholds (cfg_we/cfg_idx/cfg_wdata) only while the block is idle; unchecked.
// Timing:
//   A request is held in the input register; the phase machine and counters update
//   as it moves into the result register, so m_tvalid rises once the request has
//   passed both registers. One request per cycle is sustained while m_tready is high;
//   the limit is the counter update feeding the next request's compare.
// Reset:
//   aresetn is synchronous, active low; it empties both registers, returns the phase
//   to waiting, zeroes the counters and restores the default thresholds.
// Backpressure:
//   With m_tready low the result is held; one more request is still taken into the
//   input register, after which s_tready drops until the result is taken.
module speech_endpoint_detector_core #(
    parameter int COUNT_WIDTH = sed_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sed_pkg::S_TDATA_W-1:0]   s_tdata,   // voiced [0], zero pad [7:1]
    input  logic [sed_pkg::S_TUSER_W-1:0]   s_tuser,   // cmd [1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sed_pkg::M_TDATA_W-1:0]   m_tdata,   // event_res [1:0], discarded [2],
                                                       // limit_hit [3], force_accepted [4],
                                                       // phase [6:5], zero pad [7]
    input  logic                            cfg_we,
    input  logic [sed_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [sed_pkg::CFG_W-1:0]       cfg_wdata
);

    sed_pkg::cfg_t    cfg_reg;
    sed_pkg::item_t   s_item;
    sed_pkg::item_t   item;
    sed_pkg::result_t result;
    logic             item_valid;
    logic             fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_frames   <= sed_pkg::START_FRAMES_RST;
            cfg_reg.silence_frames <= sed_pkg::SILENCE_FRAMES_RST;
            cfg_reg.min_frames     <= sed_pkg::MIN_FRAMES_RST;
            cfg_reg.max_frames     <= sed_pkg::MAX_FRAMES_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                sed_pkg::CFG_START_FRAMES:   cfg_reg.start_frames   <= cfg_wdata;
                sed_pkg::CFG_SILENCE_FRAMES: cfg_reg.silence_frames <= cfg_wdata;
                sed_pkg::CFG_MIN_FRAMES:     cfg_reg.min_frames     <= cfg_wdata;
                sed_pkg::CFG_MAX_FRAMES:     cfg_reg.max_frames     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_item.cmd    = s_tuser;
    assign s_item.voiced = s_tdata[0];

    sed_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sed_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    sed_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .fire       (fire),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- sv/sed_in_stage.sv -----
// Input register of the endpoint detector: holds one request until the core takes it.
// Depends on sed_pkg.
module sed_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sed_pkg::item_t s_item,
    input  logic          advance,
    output logic          item_valid,
    output sed_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    sed_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/sed_ctrl.sv -----
// Phase machine and run counters of the endpoint detector; one request per cycle.
// Depends on sed_pkg and speech_endpoint_detector_core_defines.svh.
`include "speech_endpoint_detector_core_defines.svh"

module sed_ctrl #(
    parameter int COUNT_WIDTH = sed_pkg::COUNT_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  sed_pkg::item_t   item,
    input  sed_pkg::cfg_t    cfg,
    output sed_pkg::result_t result
);

    localparam int CMP_W = (COUNT_WIDTH > sed_pkg::CFG_W) ? COUNT_WIDTH : sed_pkg::CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef enum logic [sed_pkg::PHASE_W-1:0] {
        PH_WAITING  = 2'd0,
        PH_SPEAKING = 2'd1,
        PH_DONE     = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] vrun_reg, vrun_next;
    logic [COUNT_WIDTH-1:0] srun_reg, srun_next;
    logic [COUNT_WIDTH-1:0] ulen_reg, ulen_next;

    logic [COUNT_WIDTH-1:0] vrun_inc, srun_inc, ulen_inc, srun_step;
    logic                   sil_end, max_end, long_enough;
    sed_pkg::result_t       res;

    assign vrun_inc  = (vrun_reg == CNT_MAX) ? vrun_reg : vrun_reg + CNT_ONE;
    assign srun_inc  = (srun_reg == CNT_MAX) ? srun_reg : srun_reg + CNT_ONE;
    assign ulen_inc  = (ulen_reg == CNT_MAX) ? ulen_reg : ulen_reg + CNT_ONE;
    assign srun_step = item.voiced ? '0 : srun_inc;

    assign sil_end     = CMP_W'(srun_step) >= CMP_W'(cfg.silence_frames);
    assign max_end     = CMP_W'(ulen_inc) >= CMP_W'(cfg.max_frames);
    assign long_enough = CMP_W'(ulen_inc) >= CMP_W'(cfg.min_frames);

    always_comb begin
        phase_next = phase_reg;
        vrun_next  = vrun_reg;
        srun_next  = srun_reg;
        ulen_next  = ulen_reg;
        res        = '0;
        if (fire) begin
            unique case (item.cmd)
                sed_pkg::CMD_FRAME: begin
                    unique case (phase_reg)
                        PH_WAITING: begin
                            if (item.voiced) begin
                                vrun_next = vrun_inc;
                                if (CMP_W'(vrun_inc) >= CMP_W'(cfg.start_frames)) begin
                                    phase_next    = PH_SPEAKING;
                                    srun_next     = '0;
                                    ulen_next     = CNT_ONE;
                                    res.event_res = sed_pkg::EV_START;
                                end
                            end else begin
                                vrun_next = '0;
                            end
                        end
                        PH_SPEAKING: begin
                            ulen_next = ulen_inc;
                            srun_next = srun_step;
                            if (sil_end || max_end) begin
                                res.limit_hit = max_end;
                                if (long_enough) begin
                                    phase_next    = PH_DONE;
                                    res.event_res = sed_pkg::EV_END;
                                end else begin
                                    phase_next    = PH_WAITING;
                                    vrun_next     = '0;
                                    srun_next     = '0;
                                    ulen_next     = '0;
                                    res.discarded = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // done: frames are ignored until cleared
                        end
                    endcase
                end
                sed_pkg::CMD_CLEAR: begin
                    phase_next = PH_WAITING;
                    vrun_next  = '0;
                    srun_next  = '0;
                    ulen_next  = '0;
                end
                sed_pkg::CMD_FORCE: begin
                    if (phase_reg == PH_SPEAKING &&
                        CMP_W'(ulen_reg) >= CMP_W'(cfg.min_frames)) begin
                        phase_next         = PH_DONE;
                        res.force_accepted = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        res.phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_WAITING;
            vrun_reg  <= '0;
            srun_reg  <= '0;
            ulen_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            vrun_reg  <= vrun_next;
            srun_reg  <= srun_next;
            ulen_reg  <= ulen_next;
        end
    end

    assign result = res;

    `SED_ASSERT(a_force_to_done, fire && res.force_accepted |=> phase_reg == PH_DONE, "force end did not reach done")
    `SED_ASSERT(a_start_len_one, fire && res.event_res == sed_pkg::EV_START |=> ulen_reg == CNT_ONE && srun_reg == '0, "utterance start did not set length to one")
    `SED_ASSERT(a_discard_clears, fire && res.discarded |=> phase_reg == PH_WAITING && ulen_reg == '0 && vrun_reg == '0, "discard did not clear state")
    `SED_ASSERT(a_done_holds, phase_reg == PH_DONE && !(fire && item.cmd == sed_pkg::CMD_CLEAR) |=> phase_reg == PH_DONE, "left done without a clear")
    `SED_ASSERT(a_idle_holds, !fire |=> $stable(phase_reg) && $stable(ulen_reg), "state moved without a request")

endmodule

// ----- sv/sed_out_stage.sv -----
// Result register of the endpoint detector: packs a result and holds it under backpressure.
// Depends on sed_pkg.
module sed_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            item_valid,
    input  sed_pkg::result_t                result,
    output logic                            fire,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sed_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int RES_W = $bits(sed_pkg::result_t);

    logic                          valid_reg, valid_next;
    logic [sed_pkg::M_TDATA_W-1:0] data_reg;
    logic                          can_load;

    assign can_load   = !valid_reg || m_tready;
    assign fire       = item_valid && can_load;
    assign valid_next = can_load ? item_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // event_res [1:0], discarded [2], limit_hit [3], force_accepted [4], phase [6:5]
    always_ff @(posedge aclk) begin
        if (fire) begin
            data_reg <= {{(sed_pkg::M_TDATA_W - RES_W){1'b0}}, result};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
